@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define SKF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define SKF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/skf_pkg.sv @@
`default_nettype none

package skf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned CNT_W     = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PROCESS_NOISE     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MEASUREMENT_NOISE = cfg_idx_t'(1);

    localparam logic [DATA_W-1:0] NOISE_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] measurement;
        logic [TICK_W-1:0]        elapsed_ticks;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [DATA_W-1:0]        covariance;
        logic [GAIN_W-1:0]        gain;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Q,
        ST_PRED,
        ST_DIV,
        ST_MUL_E,
        ST_UPD_E,
        ST_MUL_P,
        ST_UPD_P,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_Q_TICKS,
        MUL_K_DIFF,
        MUL_K_COV
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     pred_en;
        logic     div_en;
        logic     est_en;
        logic     cov_en;
        logic     out_en;
    } ctrl_t;

endpackage

`default_nettype wire

@@ hdl/skf_ctrl.sv @@
`default_nettype none

module skf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            m_busy,
    output logic                 s_ready,
    output skf_pkg::ctrl_t       ctrl,
    output skf_pkg::state_t      state
);

    skf_pkg::state_t                 state_reg, state_next;
    logic [skf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skf_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE: begin
                if (s_valid) state_next = skf_pkg::ST_MUL_Q;
            end
            skf_pkg::ST_MUL_Q: state_next = skf_pkg::ST_PRED;
            skf_pkg::ST_PRED: begin
                cnt_next   = skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);
                state_next = skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) state_next = skf_pkg::ST_MUL_E;
            end
            skf_pkg::ST_MUL_E: state_next = skf_pkg::ST_UPD_E;
            skf_pkg::ST_UPD_E: state_next = skf_pkg::ST_MUL_P;
            skf_pkg::ST_MUL_P: state_next = skf_pkg::ST_UPD_P;
            skf_pkg::ST_UPD_P: state_next = skf_pkg::ST_DONE;
            skf_pkg::ST_DONE: begin
                if (!m_busy) state_next = skf_pkg::ST_IDLE;
            end
            default: state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        ctrl         = '0;
        ctrl.mul_sel = skf_pkg::MUL_Q_TICKS;
        unique case (state_reg)
            skf_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.load_in = s_valid;
            end
            skf_pkg::ST_MUL_Q: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = skf_pkg::MUL_Q_TICKS;
            end
            skf_pkg::ST_PRED: ctrl.pred_en = 1'b1;
            skf_pkg::ST_DIV:  ctrl.div_en  = 1'b1;
            skf_pkg::ST_MUL_E: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = skf_pkg::MUL_K_DIFF;
            end
            skf_pkg::ST_UPD_E: ctrl.est_en = 1'b1;
            skf_pkg::ST_MUL_P: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = skf_pkg::MUL_K_COV;
            end
            skf_pkg::ST_UPD_P: ctrl.cov_en = 1'b1;
            skf_pkg::ST_DONE:  ctrl.out_en = !m_busy;
            default: ;
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

@@ hdl/skf_dp.sv @@
`default_nettype none

module skf_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire skf_pkg::ctrl_t               ctrl,
    input  wire skf_pkg::in_t                 s_data,
    input  wire logic [skf_pkg::DATA_W-1:0]   process_noise,
    input  wire logic [skf_pkg::DATA_W-1:0]   measurement_noise,
    output skf_pkg::out_t                     result
);

    logic signed [31:0] z_reg, z_next;
    logic [15:0]        ticks_reg, ticks_next;
    logic signed [31:0] est_reg, est_next;
    logic [31:0]        cov_reg, cov_next;
    logic               first_reg, first_next;
    logic [31:0]        p_reg, p_next;
    logic [32:0]        sum_reg, sum_next;
    logic [33:0]        rem_reg, rem_next;
    logic [16:0]        k_reg, k_next;
    logic signed [51:0] prod_reg, prod_next;

    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [32:0] diff;
    logic [48:0]        pred_full;
    logic [31:0]        p_sat;
    logic [34:0]        trial;
    logic               ge;
    logic [33:0]        rem_keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg   <= '0;
            cov_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            est_reg   <= est_next;
            cov_reg   <= cov_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg     <= z_next;
        ticks_reg <= ticks_next;
        p_reg     <= p_next;
        sum_reg   <= sum_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
    end

    // shared multiplier operands
    assign diff = 33'(signed'({z_reg[31], z_reg})) - 33'(signed'({est_reg[31], est_reg}));

    always_comb begin
        case (ctrl.mul_sel)
            skf_pkg::MUL_Q_TICKS: begin
                mul_a = signed'({2'b00, process_noise});
                mul_b = signed'({2'b00, ticks_reg});
            end
            skf_pkg::MUL_K_DIFF: begin
                mul_a = signed'({diff[32], diff});
                mul_b = signed'({1'b0, k_reg});
            end
            skf_pkg::MUL_K_COV: begin
                mul_a = signed'({2'b00, p_reg});
                mul_b = signed'({1'b0, k_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pred_full = {17'b0, cov_reg} + {1'b0, prod_reg[47:0]};
    assign p_sat     = (|pred_full[48:32]) ? 32'hFFFF_FFFF : pred_full[31:0];

    // restoring division step, zero divisor yields zero gain
    assign trial    = {1'b0, rem_reg} - {2'b00, sum_reg};
    assign ge       = !trial[34] && (sum_reg != '0);
    assign rem_keep = ge ? trial[33:0] : rem_reg;

    always_comb begin
        z_next     = z_reg;
        ticks_next = ticks_reg;
        est_next   = est_reg;
        cov_next   = cov_reg;
        first_next = first_reg;
        p_next     = p_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;

        if (ctrl.load_in) begin
            z_next     = s_data.measurement;
            ticks_next = s_data.elapsed_ticks;
            if (first_reg) begin
                est_next   = s_data.measurement;
                first_next = 1'b0;
            end
        end
        if (ctrl.mul_en) begin
            prod_next = 52'(mul_a * mul_b);
        end
        if (ctrl.pred_en) begin
            p_next   = p_sat;
            sum_next = {1'b0, p_sat} + {1'b0, measurement_noise};
            rem_next = {2'b00, p_sat};
            k_next   = '0;
        end
        if (ctrl.div_en) begin
            k_next   = {k_reg[15:0], ge};
            rem_next = {rem_keep[32:0], 1'b0};
        end
        if (ctrl.est_en) begin
            est_next = est_reg + signed'(prod_reg[47:16]);
        end
        if (ctrl.cov_en) begin
            cov_next = p_reg - prod_reg[47:16];
        end
    end

    assign result.estimate   = est_reg;
    assign result.covariance = cov_reg;
    assign result.gain       = k_reg;

endmodule

`default_nettype wire

@@ hdl/scalar_kalman_filter_core.sv @@
// One-dimensional Kalman filter on a signed Q16.16 sensor stream. Each transaction
// takes one pass through the shared 34x18 multiplier and one saturating add for the
// prediction, 17 restoring-division steps for the gain, two more multiplier passes
// each followed by an update step for the estimate and covariance, and a load of the
// output register; s_ready stays low during that work, so the next transaction is
// accepted only after it. If the previous result has not been taken when the block
// reaches its last step, the block holds there until it is. A finished result waits
// in the output register while the next transaction is accepted. The first transaction
// after reset seeds the estimate. The user must write the registers only while the
// block is idle, through cfg_we/cfg_index/cfg_data; the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module scalar_kalman_filter_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire skf_pkg::cfg_idx_t              cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire skf_pkg::in_t                   s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output skf_pkg::out_t                       m_data
);

    logic [skf_pkg::DATA_W-1:0] process_noise_reg, process_noise_next;
    logic [skf_pkg::DATA_W-1:0] measurement_noise_reg, measurement_noise_next;
    logic                       m_valid_reg, m_valid_next;
    skf_pkg::out_t              m_data_reg, m_data_next;

    skf_pkg::ctrl_t  ctrl;
    skf_pkg::state_t state;
    skf_pkg::out_t   result;
    logic            m_busy;

    assign m_busy = m_valid_reg && !m_ready;

    skf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_busy  (m_busy),
        .s_ready (s_ready),
        .ctrl    (ctrl),
        .state   (state)
    );

    skf_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .s_data            (s_data),
        .process_noise     (process_noise_reg),
        .measurement_noise (measurement_noise_reg),
        .result            (result)
    );

    always_comb begin
        process_noise_next     = process_noise_reg;
        measurement_noise_next = measurement_noise_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE:     process_noise_next     = cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctrl.out_en) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_noise_reg     <= skf_pkg::NOISE_RESET;
            measurement_noise_reg <= skf_pkg::NOISE_RESET;
            m_valid_reg           <= 1'b0;
        end else begin
            process_noise_reg     <= process_noise_next;
            measurement_noise_reg <= measurement_noise_next;
            m_valid_reg           <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SKF_ASSERT_IMP(a_gain_bound, m_valid, m_data.gain <= 17'd65536, "gain above one")
    `SKF_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `SKF_ASSERT_IMP(a_result_from_done, $rose(m_valid), $past(state) == skf_pkg::ST_DONE,
                    "result outside done state")

endmodule

`default_nettype wire

@@ test/scalar_kalman_filter_core_test.sv @@
`timescale 1ns / 100ps

module scalar_kalman_filter_core_test;

    localparam skf_pkg::cfg_idx_t REG_UNUSED_2 = skf_pkg::cfg_idx_t'(2);
    localparam skf_pkg::cfg_idx_t REG_UNUSED_3 = skf_pkg::cfg_idx_t'(3);

    localparam logic [31:0] MEAS_MIN = 32'h8000_0000;
    localparam logic [31:0] MEAS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NOISE_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    skf_pkg::cfg_idx_t cfg_index = skf_pkg::REG_PROCESS_NOISE;
    logic [skf_pkg::DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    skf_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    skf_pkg::out_t m_data;

    // filter state tracked alongside the block
    bit [31:0] proc_noise = skf_pkg::NOISE_RESET;
    bit [31:0] meas_noise = skf_pkg::NOISE_RESET;
    longint est_q = 0;
    bit [31:0] cov_q = '0;
    bit seed_pending = 1'b1;

    skf_pkg::out_t expected_results[$];
    int error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    scalar_kalman_filter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic skf_pkg::out_t kalman_update(skf_pkg::in_t sample);
        longint z;
        longint diff;
        longint prod;
        logic [63:0] p;
        logic [63:0] total;
        logic [63:0] k;
        skf_pkg::out_t res;
        z = longint'($signed(sample.measurement));
        if (seed_pending) begin
            est_q = z;
            seed_pending = 1'b0;
        end
        p = 64'(cov_q) + 64'(proc_noise) * 64'(sample.elapsed_ticks);
        if (p > 64'hFFFF_FFFF) begin
            p = 64'hFFFF_FFFF;
        end
        total = p + 64'(meas_noise);
        k = (total == 0) ? 64'd0 : (p << 16) / total;
        diff = z - est_q;
        prod = longint'(k) * diff;
        est_q = est_q + (prod >>> 16);
        p = p - ((k * p) >> 16);
        cov_q = p[31:0];
        res.estimate = est_q[31:0];
        res.covariance = cov_q;
        res.gain = k[skf_pkg::GAIN_W-1:0];
        return res;
    endfunction

    task automatic flag_error(string msg);
        if (error_count < 200) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    always @(posedge aclk) begin : check_result
        skf_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_error("result transaction with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_data.estimate !== want.estimate) begin
                    flag_error($sformatf("estimate expected %h got %h",
                                         want.estimate, m_data.estimate));
                end
                if (m_data.covariance !== want.covariance) begin
                    flag_error($sformatf("covariance expected %h got %h",
                                         want.covariance, m_data.covariance));
                end
                if (m_data.gain !== want.gain) begin
                    flag_error($sformatf("gain expected %h got %h",
                                         want.gain, m_data.gain));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(logic [31:0] measurement, logic [15:0] ticks);
        int unsigned gap;
        skf_pkg::in_t item;
        item.measurement = measurement;
        item.elapsed_ticks = ticks;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(kalman_update(item));
    endtask

    // drop valid and let every pending transaction drain
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_register(skf_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            skf_pkg::REG_PROCESS_NOISE: proc_noise = value;
            skf_pkg::REG_MEASUREMENT_NOISE: meas_noise = value;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] random_noise();
        case ($urandom_range(5))
            0: return '0;
            1: return NOISE_MAX;
            2: return $urandom;
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_measurement();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(3))
                    0: return MEAS_MIN;
                    1: return MEAS_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return est_q[31:0] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [15:0] random_ticks();
        case ($urandom_range(9))
            0: return $urandom_range(TICKS_MAX);
            1: return TICKS_MAX;
            2: return '0;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic test_seed_and_saturation();
        send_sample(MEAS_MIN, 16'd0);
        send_sample(MEAS_MAX, TICKS_MAX);
        send_sample(MEAS_MAX, TICKS_MAX);
        send_sample(32'h0000_0000, 16'd1);
        send_sample(32'hFFFF_FFFF, 16'd0);
        wait_until_idle();
    endtask

    task automatic test_register_writes();
        write_register(REG_UNUSED_2, 32'hDEAD_BEEF);
        write_register(REG_UNUSED_3, '0);
        write_register(skf_pkg::REG_PROCESS_NOISE, '0);
        write_register(skf_pkg::REG_MEASUREMENT_NOISE, '0);
        send_sample(32'h0001_0000, 16'd3);
        send_sample(32'h7FFF_0000, 16'd100);
        send_sample(MEAS_MIN, TICKS_MAX);
        wait_until_idle();
        write_register(skf_pkg::REG_PROCESS_NOISE, NOISE_MAX);
        write_register(skf_pkg::REG_MEASUREMENT_NOISE, NOISE_MAX);
        send_sample(MEAS_MAX, 16'd1);
        send_sample(MEAS_MIN, 16'd0);
        wait_until_idle();
    endtask

    task automatic test_measurement_extremes();
        write_register(skf_pkg::REG_PROCESS_NOISE, 32'h1000_0000);
        write_register(skf_pkg::REG_MEASUREMENT_NOISE, 32'd1);
        repeat (3) begin
            send_sample(MEAS_MIN, 16'd1);
            send_sample(MEAS_MAX, 16'd1);
        end
        send_sample(32'h0000_0000, 16'd0);
        send_sample(32'hFFFF_FFFF, 16'd2);
        wait_until_idle();
    endtask

    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                       int unsigned count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            write_register(skf_pkg::REG_PROCESS_NOISE, random_noise());
            write_register(skf_pkg::REG_MEASUREMENT_NOISE, random_noise());
            repeat (count) send_sample(random_measurement(), random_ticks());
            wait_until_idle();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_seed_and_saturation();
        test_register_writes();
        test_measurement_extremes();
        test_random_traffic(0, 0, 206);
        test_random_traffic(71, 0, 206);
        test_random_traffic(0, 71, 206);
        test_random_traffic(8, 8, 206);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
